// ===== rtl/core/hill_cipher_block_transform_assert.svh =====
// assertion helpers shared by the hill transform rtl
`ifndef HILL_CIPHER_BLOCK_TRANSFORM_ASSERT_SVH
`define HILL_CIPHER_BLOCK_TRANSFORM_ASSERT_SVH

`ifndef SYNTHESIS
// condition must hold at every clock edge outside reset
`define HCBT_ASSERT(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("hcbt check failed");
// antecedent implies consequent on the same edge
`define HCBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hcbt implication failed");
`else
`define HCBT_ASSERT(lbl, clk, rst_n, cond)
`define HCBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/hcbt_pkg.sv =====
package hcbt_pkg;

  localparam int SYM_W     = 8;   // message byte, signed
  localparam int OUT_W     = 7;   // residue symbol
  localparam int ENTRY_W   = 7;   // key matrix entry
  localparam int KEY_ROW_W = 56;  // key row register
  localparam int CFG_IDX_W = 3;   // key row index
  localparam int PROD_W    = 16;  // entry times byte

  // per-cycle control broadcast from the sequencer to every cell
  typedef struct packed {
    logic acc_en;        // a product is ready for accumulation
    logic acc_first;     // product belongs to the first byte of a block
    logic res_wr;        // finished row parks in the holding rank
    logic out_load;      // output chain takes a new block
    logic out_from_res;  // new block comes from the holding rank
    logic out_shift;     // head symbol transferred, chain moves one place
  } cell_ctrl_t;

endpackage

// ===== rtl/core/hcbt_in_if.sv =====
interface hcbt_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [hcbt_pkg::SYM_W-1:0] symbol_in;
  logic                             message_start;

  modport source (output valid, output symbol_in, output message_start, input ready);
  modport sink   (input valid, input symbol_in, input message_start, output ready);
endinterface

// ===== rtl/core/hcbt_out_if.sv =====
interface hcbt_out_if;
  logic                       valid;
  logic                       ready;
  logic [hcbt_pkg::OUT_W-1:0] symbol_out;
  logic                       block_last;

  modport source (output valid, output symbol_out, output block_last, input ready);
  modport sink   (input valid, input symbol_out, input block_last, output ready);
endinterface

// ===== rtl/core/hcbt_cfg_if.sv =====
interface hcbt_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [hcbt_pkg::CFG_IDX_W-1:0] index;
  logic [hcbt_pkg::KEY_ROW_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/hcbt_cell.sv =====
module hcbt_cell #(
  parameter int BLOCK_SIZE = 4,
  parameter int MODULUS    = 128
) (
  input  logic                                clk,
  input  logic [hcbt_pkg::ENTRY_W*BLOCK_SIZE-1:0] key_row,
  input  logic signed [hcbt_pkg::SYM_W-1:0]   s1_byte,
  input  logic [$clog2(BLOCK_SIZE)-1:0]       s1_pos,
  input  hcbt_pkg::cell_ctrl_t                ctrl,
  input  logic [hcbt_pkg::OUT_W-1:0]          chain_in,
  output logic [hcbt_pkg::OUT_W-1:0]          chain_out
);

  localparam int OUT_W   = hcbt_pkg::OUT_W;
  localparam int ENTRY_W = hcbt_pkg::ENTRY_W;
  localparam int PROD_W  = hcbt_pkg::PROD_W;
  // smallest multiple of the modulus that lifts every product to >= 0
  localparam int MinProd = 127 * 128;
  localparam int OFFSET  = ((MinProd + MODULUS - 1) / MODULUS) * MODULUS;

  typedef logic [127:0][OUT_W-1:0] hi_tbl_t;
  typedef logic [255:0][OUT_W-1:0] lo_tbl_t;

  function automatic hi_tbl_t build_hi();
    hi_tbl_t tbl;
    for (int k = 0; k < 128; k++) begin
      tbl[k] = OUT_W'((k * 256) % MODULUS);
    end
    return tbl;
  endfunction

  function automatic lo_tbl_t build_lo();
    lo_tbl_t tbl;
    for (int k = 0; k < 256; k++) begin
      tbl[k] = OUT_W'(k % MODULUS);
    end
    return tbl;
  endfunction

  localparam hi_tbl_t HI_TBL = build_hi();
  localparam lo_tbl_t LO_TBL = build_lo();

  logic [ENTRY_W-1:0]       entry;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0]        lifted;
  logic [OUT_W:0]           term_sum;
  logic [OUT_W-1:0]         term;
  logic [OUT_W:0]           acc_sum;
  logic [OUT_W-1:0]         acc_red;
  logic [OUT_W-1:0]         acc_nxt;
  logic [OUT_W-1:0]         acc_r;
  logic [OUT_W-1:0]         res_r;
  logic [OUT_W-1:0]         out_r;

  // stage 1: key entry for this byte position times the byte
  assign entry    = key_row[ENTRY_W*s1_pos +: ENTRY_W];
  assign prod_nxt = $signed({1'b0, entry}) * s1_byte;

  // stage 2: product residue from two table halves, then accumulate mod m
  assign lifted   = PROD_W'(prod_r + PROD_W'(OFFSET));
  assign term_sum = {1'b0, HI_TBL[lifted[14:8]]} + {1'b0, LO_TBL[lifted[7:0]]};
  assign term     = (term_sum >= (OUT_W+1)'(MODULUS)) ?
                    OUT_W'(term_sum - (OUT_W+1)'(MODULUS)) : term_sum[OUT_W-1:0];
  assign acc_sum  = {1'b0, acc_r} + {1'b0, term};
  assign acc_red  = (acc_sum >= (OUT_W+1)'(MODULUS)) ?
                    OUT_W'(acc_sum - (OUT_W+1)'(MODULUS)) : acc_sum[OUT_W-1:0];
  assign acc_nxt  = ctrl.acc_first ? term : acc_red;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctrl.acc_en) begin
      acc_r <= acc_nxt;
    end
    if (ctrl.res_wr) begin
      res_r <= acc_nxt;
    end
    if (ctrl.out_load) begin
      out_r <= ctrl.out_from_res ? res_r : acc_nxt;
    end else if (ctrl.out_shift) begin
      out_r <= chain_in;
    end
  end

  assign chain_out = out_r;

endmodule

// ===== rtl/core/hill_cipher_block_transform.sv =====
// hill block transform, key matrix times a block of signed bytes, mod MODULUS
//
// channels: cfg_ch writes key row i (index i, 7-bit entry j in slot j); it is
// always ready; the user must write it only while the block is idle, which
// the block does not enforce. in_ch transfers one signed byte per cycle
// while ready; message_start drops any partial block first. out_ch delivers
// BLOCK_SIZE residues per full block, block_last on the final one. trailing
// bytes of an incomplete block give nothing.
// throughput: one byte per cycle sustained, one symbol per cycle out, both
// while out_ch is ready. the last byte of a block is registered in stage 1,
// multiplied into stage 2, then accumulated into the output chain or, while
// the chain is busy, the holding rank. each of the BLOCK_SIZE cells owns one
// key row and accumulates its row residue as the bytes stream by, so the
// rate is set by the per-cycle multiply-accumulate in each cell and the
// shift-out of the output chain.
// reset (rst_n low, synchronous) clears key rows, fill position and all
// pipeline and chain occupancy. when out_ch stalls, finished blocks wait in
// the output chain plus one holding rank; in_ch then holds off only a byte
// arriving at the last fill position while two finished blocks wait.
`include "hill_cipher_block_transform_assert.svh"

module hill_cipher_block_transform #(
  parameter int BLOCK_SIZE = 4,
  parameter int MODULUS    = 128
) (
  input  logic             clk,
  input  logic             rst_n,
  hcbt_cfg_if.sink         cfg_ch,
  hcbt_in_if.sink          in_ch,
  hcbt_out_if.source       out_ch
);

  localparam int OUT_W    = hcbt_pkg::OUT_W;
  localparam int SYM_W    = hcbt_pkg::SYM_W;
  localparam int ENTRY_W  = hcbt_pkg::ENTRY_W;
  localparam int ROW_W    = ENTRY_W * BLOCK_SIZE;
  localparam int POS_W    = $clog2(BLOCK_SIZE);
  localparam int CNT_W    = $clog2(BLOCK_SIZE + 1);
  localparam int CFG_IDX_W = hcbt_pkg::CFG_IDX_W;

  // key storage, only rows that the block size uses
  logic [ROW_W-1:0] key_r [BLOCK_SIZE];

  // input side
  logic [POS_W-1:0] fill_r;
  logic [POS_W-1:0] fill_nxt;
  logic [POS_W-1:0] pos;
  logic             in_fire;
  logic             completes;

  // stage 1: byte and position on their way to the multipliers
  logic                    s1_valid_r;
  logic signed [SYM_W-1:0] s1_byte_r;
  logic [POS_W-1:0]        s1_pos_r;
  logic                    s1_first_r;
  logic                    s1_last_r;

  // stage 2: products registered inside the cells
  logic s2_valid_r;
  logic s2_first_r;
  logic s2_last_r;

  // finished blocks anywhere between input and output, at most two
  logic [1:0] blocks_r;
  logic [1:0] blocks_nxt;

  // output chain occupancy and holding rank
  logic [CNT_W-1:0] out_cnt_r;
  logic [CNT_W-1:0] out_cnt_nxt;
  logic             res_valid_r;
  logic             res_valid_nxt;
  logic             out_fire;
  logic             drain_last;
  logic             can_load;

  hcbt_pkg::cell_ctrl_t ctrl;
  logic [OUT_W-1:0]     chain [BLOCK_SIZE+1];

  assign cfg_ch.ready = 1'b1;

  // key rows, write ignored for rows above the block size
  always_ff @(posedge clk) begin
    for (int i = 0; i < BLOCK_SIZE; i++) begin
      if (!rst_n) begin
        key_r[i] <= '0;
      end else if (cfg_ch.valid && cfg_ch.index == CFG_IDX_W'(i)) begin
        key_r[i] <= cfg_ch.data[ROW_W-1:0];
      end
    end
  end

  // --- input acceptance ---
  assign out_fire   = out_ch.valid && out_ch.ready;
  assign drain_last = out_fire && (out_cnt_r == CNT_W'(1));
  // only a byte that arrives at the last fill position can be held off
  assign in_ch.ready = (fill_r != POS_W'(BLOCK_SIZE - 1)) ||
                       (blocks_r != 2'd2) || drain_last;
  assign in_fire    = in_ch.valid && in_ch.ready;
  assign pos        = in_ch.message_start ? '0 : fill_r;
  assign completes  = (pos == POS_W'(BLOCK_SIZE - 1));
  assign fill_nxt   = completes ? '0 : POS_W'(pos + 1'b1);

  always_comb begin
    blocks_nxt = blocks_r;
    if (in_fire && completes && !drain_last) begin
      blocks_nxt = blocks_r + 2'd1;
    end else if (drain_last && !(in_fire && completes)) begin
      blocks_nxt = blocks_r - 2'd1;
    end
  end

  // --- output chain load: straight from the cells, else via holding rank ---
  assign can_load = (out_cnt_r == '0) || drain_last;

  always_comb begin
    ctrl.acc_en       = s2_valid_r;
    ctrl.acc_first    = s2_first_r;
    ctrl.out_load     = can_load && (res_valid_r || (s2_valid_r && s2_last_r));
    ctrl.out_from_res = res_valid_r;
    ctrl.res_wr       = s2_valid_r && s2_last_r && !(can_load && !res_valid_r);
    ctrl.out_shift    = out_fire;
  end

  assign res_valid_nxt = ctrl.res_wr || (res_valid_r && !can_load);

  always_comb begin
    out_cnt_nxt = out_cnt_r;
    if (ctrl.out_load) begin
      out_cnt_nxt = CNT_W'(BLOCK_SIZE);
    end else if (out_fire) begin
      out_cnt_nxt = out_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      blocks_r    <= 2'd0;
      out_cnt_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        fill_r <= fill_nxt;
      end
      s1_valid_r  <= in_fire;
      s2_valid_r  <= s1_valid_r;
      blocks_r    <= blocks_nxt;
      out_cnt_r   <= out_cnt_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // payload of the two pipeline stages
  always_ff @(posedge clk) begin
    s1_byte_r  <= in_ch.symbol_in;
    s1_pos_r   <= pos;
    s1_first_r <= (pos == '0);
    s1_last_r  <= completes;
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
  end

  // --- row of cells, output chain shifts toward cell 0 ---
  assign chain[BLOCK_SIZE] = '0;

  for (genvar gi = 0; gi < BLOCK_SIZE; gi++) begin : g_cell
    hcbt_cell #(
      .BLOCK_SIZE (BLOCK_SIZE),
      .MODULUS    (MODULUS)
    ) u_cell (
      .clk       (clk),
      .key_row   (key_r[gi]),
      .s1_byte   (s1_byte_r),
      .s1_pos    (s1_pos_r),
      .ctrl      (ctrl),
      .chain_in  (chain[gi+1]),
      .chain_out (chain[gi])
    );
  end

  assign out_ch.valid      = (out_cnt_r != '0);
  assign out_ch.symbol_out = chain[0];
  assign out_ch.block_last = (out_cnt_r == CNT_W'(1));

  // --- checks ---
  `HCBT_ASSERT(a_blocks_bound, clk, rst_n, blocks_r != 2'd3)
  `HCBT_ASSERT(a_cnt_bound, clk, rst_n, out_cnt_r <= CNT_W'(BLOCK_SIZE))
  `HCBT_ASSERT_IMP(a_res_waits_on_chain, clk, rst_n, res_valid_r, out_cnt_r != '0)
  `HCBT_ASSERT_IMP(a_drain_counted, clk, rst_n, drain_last, blocks_r != 2'd0)
  `HCBT_ASSERT_IMP(a_no_res_overrun, clk, rst_n, s2_valid_r && s2_last_r && res_valid_r, can_load)

endmodule
